/* rtl/psfl_pkg.sv */
// Shared types and codes for the packet slot free list queue.
package psfl_pkg;

  // Field widths fixed by the stream formats
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned IN_USER_W = 2;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_FLUSH   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_DISABLED  = 3'd2,
    ST_NO_FREE   = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FREE_FULL = 3'd5
  } status_t;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_ENQ   = 7'b0000100,
    S_DQ1   = 7'b0001000,
    S_DQ2   = 7'b0010000,
    S_FLUSH = 7'b0100000,
    S_RESP  = 7'b1000000
  } fsm_t;

endpackage

/* rtl/packet_slot_free_list_queue_core.sv */
// Slot manager: free list ring, send FIFO ring and per-slot length store.
//
// Channels: in_* carries one action per transfer (enqueue, dequeue, release, flush),
// out_* returns exactly one result per action, cfg_* writes the enable bit.
// A result sits in an output register; the next action is taken in the same
// cycle that register is loaded, so a stalled receiver does not block intake
// until a second result is ready.
// Steps per action, from the accept cycle to the result register load: release and
// refused actions load it directly, enqueue first reads the free ring, dequeue reads
// the send ring, then the length store; flush with an empty queue does no ring reads,
// otherwise it moves one send ring entry per cycle, then the last push, then closes.
// Every memory has one write and one registered read port; actions run one at a
// time, so no forwarding is needed.
// Reset: synchronous, active low. After reset a fill pass writes entry i of the
// free ring with i while in_tready is low; cfg writes are taken throughout.
// The enable bit resets to 0.
// When out_tready is low, the finished result waits in the output register and
// the block holds the next result in S_RESP until the register drains.
module packet_slot_free_list_queue_core #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned MAX_PACKET = 2048
) (
  input  logic clk,
  input  logic rst_n,
  // config write channel: enabled
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data,
  // action stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [psfl_pkg::IN_DATA_W-1:0]       in_tdata,  // pkt_length, release_slot
  input  logic [psfl_pkg::IN_USER_W-1:0]       in_tuser,  // action
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // result_slot, result_length, free_slots, queued_slots, zero pad
  output logic [psfl_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [psfl_pkg::OUT_USER_W-1:0]      out_tuser  // ok, status
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = psfl_pkg::LEN_W;
  localparam int unsigned RELN = 1 << psfl_pkg::SLOT_W;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    ptr_inc = (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // release index reduced modulo DEPTH through a constant table
  logic [IW-1:0] rel_tab [RELN];
  for (genvar g = 0; g < RELN; g++) begin : g_rel
    assign rel_tab[g] = IW'(g % DEPTH);
  end

  // memories
  logic [IW-1:0] free_ring [DEPTH];
  logic [IW-1:0] send_ring [DEPTH];
  logic [LW-1:0] slot_len  [DEPTH];

  logic          fr_we, sr_we, sl_we;
  logic [IW-1:0] fr_wa, fr_wd, fr_ra, fr_rd;
  logic [IW-1:0] sr_wa, sr_wd, sr_ra, sr_rd;
  logic [IW-1:0] sl_wa, sl_ra;
  logic [LW-1:0] sl_wd, sl_rd;

  always_ff @(posedge clk) begin
    if (fr_we) free_ring[fr_wa] <= fr_wd;
    fr_rd <= free_ring[fr_ra];
  end

  always_ff @(posedge clk) begin
    if (sr_we) send_ring[sr_wa] <= sr_wd;
    sr_rd <= send_ring[sr_ra];
  end

  always_ff @(posedge clk) begin
    if (sl_we) slot_len[sl_wa] <= sl_wd;
    sl_rd <= slot_len[sl_ra];
  end

  // control state
  psfl_pkg::fsm_t st_r, st_nxt;
  logic           enabled_r, enabled_nxt;
  logic [IW-1:0]  init_cnt_r, init_cnt_nxt;
  logic [IW-1:0]  free_rd_r, free_rd_nxt, free_wr_r, free_wr_nxt;
  logic [IW-1:0]  send_rd_r, send_rd_nxt, send_wr_r, send_wr_nxt;
  logic [CW-1:0]  free_total_r, free_total_nxt, send_total_r, send_total_nxt;
  logic           fl_pend_r, fl_pend_nxt;
  logic           out_valid_r, out_valid_nxt;

  // payload
  logic [LW-1:0]                      len_r, len_nxt;
  logic                               res_ok_r, res_ok_nxt;
  logic [IW-1:0]                      res_slot_r, res_slot_nxt;
  logic [LW-1:0]                      res_len_r, res_len_nxt;
  psfl_pkg::status_t                  res_status_r, res_status_nxt;
  logic [psfl_pkg::OUT_DATA_W-1:0]    out_data_r, out_data_nxt;
  logic [psfl_pkg::OUT_USER_W-1:0]    out_user_r, out_user_nxt;

  logic                  out_free, take, free_room;
  psfl_pkg::action_t     in_action;
  logic [LW-1:0]         in_len;
  logic [IW-1:0]         in_rel;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (st_r == psfl_pkg::S_IDLE) || ((st_r == psfl_pkg::S_RESP) && out_free);
  assign take      = in_tvalid && in_tready;
  assign free_room = free_total_r < CW'(DEPTH);

  assign in_action = psfl_pkg::action_t'(in_tuser);
  assign in_len    = in_tdata[LW-1:0];
  assign in_rel    = rel_tab[in_tdata[LW +: psfl_pkg::SLOT_W]];

  always_comb begin
    st_nxt         = st_r;
    enabled_nxt    = (cfg_valid && cfg_ready) ? cfg_data : enabled_r;
    init_cnt_nxt   = init_cnt_r;
    free_rd_nxt    = free_rd_r;
    free_wr_nxt    = free_wr_r;
    send_rd_nxt    = send_rd_r;
    send_wr_nxt    = send_wr_r;
    free_total_nxt = free_total_r;
    send_total_nxt = send_total_r;
    fl_pend_nxt    = fl_pend_r;
    len_nxt        = len_r;
    res_ok_nxt     = res_ok_r;
    res_slot_nxt   = res_slot_r;
    res_len_nxt    = res_len_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;

    fr_we = 1'b0; fr_wa = free_wr_r; fr_wd = '0; fr_ra = free_rd_r;
    sr_we = 1'b0; sr_wa = send_wr_r; sr_wd = '0; sr_ra = send_rd_r;
    sl_we = 1'b0; sl_wa = '0;        sl_wd = '0; sl_ra = sr_rd;

    unique case (st_r)
      psfl_pkg::S_INIT: begin
        fr_we = 1'b1;
        fr_wa = init_cnt_r;
        fr_wd = init_cnt_r;
        init_cnt_nxt = ptr_inc(init_cnt_r);
        if (init_cnt_r == IW'(DEPTH - 1)) st_nxt = psfl_pkg::S_IDLE;
      end
      psfl_pkg::S_IDLE: ;
      psfl_pkg::S_ENQ: begin
        // free ring head is in fr_rd
        sl_we = 1'b1; sl_wa = fr_rd; sl_wd = len_r;
        sr_we = 1'b1; sr_wa = send_wr_r; sr_wd = fr_rd;
        free_rd_nxt    = ptr_inc(free_rd_r);
        free_total_nxt = free_total_r - 1'b1;
        send_wr_nxt    = ptr_inc(send_wr_r);
        send_total_nxt = send_total_r + 1'b1;
        res_ok_nxt = 1'b1; res_slot_nxt = fr_rd; res_len_nxt = len_r;
        res_status_nxt = psfl_pkg::ST_OK;
        st_nxt = psfl_pkg::S_RESP;
      end
      psfl_pkg::S_DQ1: begin
        sl_ra = sr_rd;
        res_slot_nxt   = sr_rd;
        send_rd_nxt    = ptr_inc(send_rd_r);
        send_total_nxt = send_total_r - 1'b1;
        st_nxt = psfl_pkg::S_DQ2;
      end
      psfl_pkg::S_DQ2: begin
        res_ok_nxt = 1'b1; res_len_nxt = sl_rd; res_status_nxt = psfl_pkg::ST_OK;
        st_nxt = psfl_pkg::S_RESP;
      end
      psfl_pkg::S_FLUSH: begin
        // write side: push the entry read last cycle unless the free list is full
        if (fl_pend_r && free_room) begin
          fr_we = 1'b1; fr_wa = free_wr_r; fr_wd = sr_rd;
          free_wr_nxt    = ptr_inc(free_wr_r);
          free_total_nxt = free_total_r + 1'b1;
        end
        // read side: one queued entry per cycle
        if (send_total_r != '0) begin
          sr_ra = send_rd_r;
          send_rd_nxt    = ptr_inc(send_rd_r);
          send_total_nxt = send_total_r - 1'b1;
          fl_pend_nxt    = 1'b1;
        end else begin
          fl_pend_nxt = 1'b0;
          if (!fl_pend_r) begin
            send_rd_nxt = '0;
            send_wr_nxt = '0;
            res_ok_nxt = 1'b1; res_slot_nxt = '0; res_len_nxt = '0;
            res_status_nxt = psfl_pkg::ST_OK;
            st_nxt = psfl_pkg::S_RESP;
          end
        end
      end
      psfl_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0000,
                           psfl_pkg::COUNT_W'(send_total_r),
                           psfl_pkg::COUNT_W'(free_total_r),
                           res_len_r,
                           psfl_pkg::SLOT_W'(res_slot_r)};
          out_user_nxt  = {res_status_r, res_ok_r};
          st_nxt = psfl_pkg::S_IDLE;
        end
      end
      default: st_nxt = psfl_pkg::S_IDLE;
    endcase

    // intake of a new action (idle, or result register loading this cycle)
    if (take) begin
      res_ok_nxt   = 1'b0;
      res_slot_nxt = '0;
      res_len_nxt  = '0;
      st_nxt       = psfl_pkg::S_RESP;
      case (in_action)
        psfl_pkg::ACT_ENQUEUE: begin
          len_nxt = in_len;
          if (in_len == '0 || in_len > LW'(MAX_PACKET)) begin
            res_status_nxt = psfl_pkg::ST_BAD_LEN;
          end else if (!enabled_r) begin
            res_status_nxt = psfl_pkg::ST_DISABLED;
          end else if (free_total_r == '0) begin
            res_status_nxt = psfl_pkg::ST_NO_FREE;
          end else begin
            fr_ra  = free_rd_r;
            st_nxt = psfl_pkg::S_ENQ;
          end
        end
        psfl_pkg::ACT_DEQUEUE: begin
          if (!enabled_r) begin
            res_status_nxt = psfl_pkg::ST_DISABLED;
          end else if (send_total_r == '0) begin
            res_status_nxt = psfl_pkg::ST_EMPTY;
          end else begin
            sr_ra  = send_rd_r;
            st_nxt = psfl_pkg::S_DQ1;
          end
        end
        psfl_pkg::ACT_RELEASE: begin
          if (free_room) begin
            fr_we = 1'b1; fr_wa = free_wr_r; fr_wd = in_rel;
            sl_we = 1'b1; sl_wa = in_rel;    sl_wd = '0;
            free_wr_nxt    = ptr_inc(free_wr_r);
            free_total_nxt = free_total_r + 1'b1;
            res_ok_nxt     = 1'b1;
            res_status_nxt = psfl_pkg::ST_OK;
          end else begin
            res_status_nxt = psfl_pkg::ST_FREE_FULL;
          end
        end
        default: begin
          // flush
          fl_pend_nxt = 1'b0;
          st_nxt      = psfl_pkg::S_FLUSH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= psfl_pkg::S_INIT;
      enabled_r    <= 1'b0;
      init_cnt_r   <= '0;
      free_rd_r    <= '0;
      free_wr_r    <= '0;
      send_rd_r    <= '0;
      send_wr_r    <= '0;
      free_total_r <= CW'(DEPTH);
      send_total_r <= '0;
      fl_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      enabled_r    <= enabled_nxt;
      init_cnt_r   <= init_cnt_nxt;
      free_rd_r    <= free_rd_nxt;
      free_wr_r    <= free_wr_nxt;
      send_rd_r    <= send_rd_nxt;
      send_wr_r    <= send_wr_nxt;
      free_total_r <= free_total_nxt;
      send_total_r <= send_total_nxt;
      fl_pend_r    <= fl_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r        <= len_nxt;
    res_ok_r     <= res_ok_nxt;
    res_slot_r   <= res_slot_nxt;
    res_len_r    <= res_len_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

endmodule
